// ===== hdl/breakpoint_axis_locator_assert.svh =====
// ----------------------------------------------------------------------------
// Breakpoint axis locator assertion macros
// Shared concurrent assertion wrappers, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_AXIS_LOCATOR_ASSERT_SVH
`define BREAKPOINT_AXIS_LOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on i_clk, off during reset
`define BAL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk, off during reset
`define BAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BAL_ASSERT_NOW(lbl, ante, cons, msg)
`define BAL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/bal_pkg.sv =====
// ----------------------------------------------------------------------------
// Breakpoint axis locator package
// Request and result types, opcodes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package bal_pkg;

    // Default axis depth
    localparam int MAX_POINTS_DEF = 16;

    // Configuration register
    localparam int             CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // Request opcodes
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOCATE = 1'b1;

    // Width of the shared subtractor (one guard bit for the divider)
    localparam int ALU_W = 17;

    typedef struct packed {
        logic        opcode;
        logic [3:0]  point_index;
        logic [15:0] sample_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  nearest_index;
        logic [15:0] span_fraction;
        logic        fraction_saturated;
        logic        degenerate_span;
    } t_out_item;

    // Sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROBE,
        ST_TEST,
        ST_FETCH,
        ST_SPAN,
        ST_DIST_K,
        ST_DIST_N,
        ST_PICK,
        ST_RANGE,
        ST_DIVIDE,
        ST_EMIT
    } t_bal_state;

endpackage

// ===== hdl/bal_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/bal_sub_unit.sv =====
// ----------------------------------------------------------------------------
// Breakpoint axis locator shared subtractor
// Difference, borrow and magnitude of two unsigned operands.
// ----------------------------------------------------------------------------
module bal_sub_unit (
    input  logic [bal_pkg::ALU_W-1:0] i_x,
    input  logic [bal_pkg::ALU_W-1:0] i_y,
    output logic [bal_pkg::ALU_W-1:0] o_diff,
    output logic                      o_borrow,
    output logic [15:0]               o_mag
);
    import bal_pkg::*;

    logic [ALU_W:0]   w_wide;
    logic [ALU_W-1:0] w_neg;

    // Subtract with one extra bit for the borrow
    assign w_wide   = {1'b0, i_x} - {1'b0, i_y};
    assign o_diff   = w_wide[ALU_W-1:0];
    assign o_borrow = w_wide[ALU_W];

    // Negate the difference when it went below zero
    assign w_neg = (~w_wide[ALU_W-1:0]) + ALU_W'(1);
    assign o_mag = o_borrow ? w_neg[15:0] : w_wide[15:0];

endmodule

// ===== hdl/bal_seq.sv =====
// ----------------------------------------------------------------------------
// Breakpoint axis locator sequencer
// Binary search, neighbor choice and restoring division on one subtractor.
// ----------------------------------------------------------------------------
`include "breakpoint_axis_locator_assert.svh"

module bal_seq #(
    parameter int MAX_POINTS = bal_pkg::MAX_POINTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  bal_pkg::t_in_item             i_item,
    input  logic [bal_pkg::CFG_W-1:0]     i_points,
    input  logic                          i_out_free,
    output bal_pkg::t_seq_stat            o_stat,
    output bal_pkg::t_out_item            o_result,
    output logic                          o_ram_we,
    output logic [$clog2(MAX_POINTS)-1:0] o_ram_waddr,
    output logic [15:0]                   o_ram_wdata,
    output logic [$clog2(MAX_POINTS)-1:0] o_ram_raddr,
    input  logic [15:0]                   i_ram_rdata
);
    import bal_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = IW + 1;

    // Zero-extend or truncate an index to the 4-bit result field
    function automatic logic [3:0] to_nib(input logic [CW-1:0] v);
        logic [CW+3:0] t;
        t = {4'b0, v};
        return t[3:0];
    endfunction

    t_bal_state      r_state, n_state;
    logic [15:0]     r_val, n_val;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_a, n_a;
    logic [CW-1:0]   r_b, n_b;
    logic [IW-1:0]   r_k, n_k;
    logic [15:0]     r_pk, n_pk;
    logic [15:0]     r_po, n_po;
    logic [15:0]     r_span, n_span;
    logic [15:0]     r_d1, n_d1;
    logic [15:0]     r_d2, n_d2;
    logic [ALU_W-1:0] r_rem, n_rem;
    logic [15:0]     r_quo, n_quo;
    logic [3:0]      r_cnt, n_cnt;
    logic            r_has_next, n_has_next;
    t_out_item       r_res, n_res;

    logic [ALU_W-1:0] w_x, w_y, w_diff;
    logic             w_borrow;
    logic [15:0]      w_mag;
    logic [CW-1:0]    w_mid;
    logic [CW-1:0]    w_kx;
    logic [CW-1:0]    w_na, w_nb;
    logic             w_eq, w_gt, w_stop;
    logic             w_has_next;
    logic             w_pick_next;
    logic [7:0]       w_cfg8;
    logic [CW-1:0]    w_n_clamp;
    logic [IW+3:0]    w_slot;
    logic [ALU_W-1:0] w_shift;
    logic             w_last;

    // Shared subtractor
    bal_sub_unit u_sub (
        .i_x      (w_x),
        .i_y      (w_y),
        .o_diff   (w_diff),
        .o_borrow (w_borrow),
        .o_mag    (w_mag)
    );

    // Search and datapath helpers
    assign w_mid      = r_a + ((r_b - r_a) >> 1);
    assign w_kx       = {1'b0, r_k};
    assign w_eq       = (w_diff == '0);
    assign w_gt       = !w_borrow && !w_eq;
    assign w_na       = w_gt ? (w_kx + CW'(1)) : r_a;
    assign w_nb       = (!w_gt && !w_eq) ? w_kx : r_b;
    assign w_stop     = w_eq || !(w_na < w_nb);
    assign w_has_next = (w_kx + CW'(1)) < r_n;
    assign w_pick_next = r_has_next && (r_span != '0) && w_borrow;
    assign w_shift    = {r_rem[ALU_W-2:0], 1'b0};
    assign w_last     = (r_cnt == 4'd15);

    // Clamp the point count to the searchable range
    assign w_cfg8 = {3'b0, i_points};
    always_comb begin
        if (w_cfg8 < 8'd2) begin
            w_n_clamp = CW'(2);
        end else if (w_cfg8 > 8'(MAX_POINTS)) begin
            w_n_clamp = CW'(MAX_POINTS);
        end else begin
            w_n_clamp = w_cfg8[CW-1:0];
        end
    end

    // Write slot decode
    assign w_slot      = {{IW{1'b0}}, i_item.point_index};
    assign o_ram_we    = i_start && (i_item.opcode == OP_WRITE)
                         && (w_slot < (IW+4)'(MAX_POINTS));
    assign o_ram_waddr = w_slot[IW-1:0];
    assign o_ram_wdata = i_item.sample_value;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_item.opcode == OP_WRITE) ? ST_EMIT : ST_PROBE;
                end
            end
            ST_PROBE:  n_state = ST_TEST;
            ST_TEST:   n_state = w_stop ? ST_FETCH : ST_PROBE;
            ST_FETCH:  n_state = ST_SPAN;
            ST_SPAN:   n_state = ST_DIST_K;
            ST_DIST_K: n_state = r_has_next ? ST_DIST_N : ST_PICK;
            ST_DIST_N: n_state = ST_PICK;
            ST_PICK:   n_state = (r_span == '0) ? ST_EMIT : ST_RANGE;
            ST_RANGE:  n_state = w_borrow ? ST_DIVIDE : ST_EMIT;
            ST_DIVIDE: n_state = w_last ? ST_EMIT : ST_DIVIDE;
            ST_EMIT:   n_state = i_out_free ? ST_IDLE : ST_EMIT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Operand select and read address
    always_comb begin
        w_x         = '0;
        w_y         = '0;
        o_ram_raddr = r_k;
        unique case (r_state)
            ST_PROBE: begin
                o_ram_raddr = w_mid[IW-1:0];
            end
            ST_TEST: begin
                w_x = {1'b0, r_val};
                w_y = {1'b0, i_ram_rdata};
            end
            ST_FETCH: begin
                o_ram_raddr = w_has_next ? (r_k + IW'(1)) : (r_k - IW'(1));
            end
            ST_SPAN: begin
                w_x = {1'b0, r_pk};
                w_y = {1'b0, i_ram_rdata};
            end
            ST_DIST_K: begin
                w_x = {1'b0, r_pk};
                w_y = {1'b0, r_val};
            end
            ST_DIST_N: begin
                w_x = {1'b0, r_po};
                w_y = {1'b0, r_val};
            end
            ST_PICK: begin
                w_x = {1'b0, r_d2};
                w_y = {1'b0, r_d1};
            end
            ST_RANGE: begin
                w_x = r_rem;
                w_y = {1'b0, r_span};
            end
            ST_DIVIDE: begin
                w_x = w_shift;
                w_y = {1'b0, r_span};
            end
            default: begin
                w_x = '0;
            end
        endcase
    end

    // Datapath register updates
    always_comb begin
        n_val      = r_val;
        n_n        = r_n;
        n_a        = r_a;
        n_b        = r_b;
        n_k        = r_k;
        n_pk       = r_pk;
        n_po       = r_po;
        n_span     = r_span;
        n_d1       = r_d1;
        n_d2       = r_d2;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_has_next = r_has_next;
        n_res      = r_res;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_val = i_item.sample_value;
                    n_n   = w_n_clamp;
                    n_a   = '0;
                    n_b   = w_n_clamp;
                    n_res = '0;
                end
            end
            ST_PROBE: begin
                n_k = w_mid[IW-1:0];
            end
            ST_TEST: begin
                n_pk = i_ram_rdata;
                n_a  = w_na;
                n_b  = w_nb;
            end
            ST_FETCH: begin
                n_has_next = w_has_next;
            end
            ST_SPAN: begin
                n_po   = i_ram_rdata;
                n_span = w_mag;
            end
            ST_DIST_K: begin
                n_d1 = w_mag;
            end
            ST_DIST_N: begin
                n_d2 = w_mag;
            end
            ST_PICK: begin
                n_res.nearest_index   = w_pick_next ? to_nib(w_kx + CW'(1)) : to_nib(w_kx);
                n_res.degenerate_span = (r_span == '0);
                n_rem                 = {1'b0, (w_pick_next ? r_d2 : r_d1)};
            end
            ST_RANGE: begin
                // Distance reached the span: saturate
                if (!w_borrow) begin
                    n_res.span_fraction      = 16'hFFFF;
                    n_res.fraction_saturated = 1'b1;
                end
                n_cnt = '0;
                n_quo = '0;
            end
            ST_DIVIDE: begin
                n_rem = w_borrow ? w_shift : w_diff;
                n_quo = {r_quo[14:0], !w_borrow};
                n_cnt = r_cnt + 4'd1;
                if (w_last) begin
                    n_res.span_fraction = {r_quo[14:0], !w_borrow};
                end
            end
            default: begin
                n_res = r_res;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_val      <= n_val;
        r_n        <= n_n;
        r_a        <= n_a;
        r_b        <= n_b;
        r_k        <= n_k;
        r_pk       <= n_pk;
        r_po       <= n_po;
        r_span     <= n_span;
        r_d1       <= n_d1;
        r_d2       <= n_d2;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_has_next <= n_has_next;
        r_res      <= n_res;
    end

    // Status and result
    assign o_stat.busy = (r_state != ST_IDLE);
    assign o_stat.done = (r_state == ST_EMIT) && i_out_free;
    assign o_result    = r_res;

    `BAL_ASSERT_NOW(a_probe_window, r_state == ST_PROBE, r_a < r_b, "probe with empty window")
    `BAL_ASSERT_NOW(a_k_in_range, r_state == ST_FETCH, w_kx < r_n, "probe index past points")
    `BAL_ASSERT_NEXT(a_probe_then_test, r_state == ST_PROBE, r_state == ST_TEST, "probe not followed by test")

endmodule

// ===== hdl/breakpoint_axis_locator.sv =====
// ----------------------------------------------------------------------------
// Breakpoint axis locator
// Loads an axis of breakpoints and locates values on it by binary search.
// ----------------------------------------------------------------------------
// Write request: ST_EMIT hands a registered result out; the next accept waits for the return to idle.
// Locate request: p probes (at most 5 for 16 points), then span, distances, pick and range check,
// then the 16-step divide; flat and saturated spans skip the 16-step divide.
// One subtractor is shared by search compares, distances and the restoring divide.
// Reset (i_rst_n low, synchronous) clears control and sets points_in_use to 16;
// the axis RAM is not cleared.
`include "breakpoint_axis_locator_assert.svh"

module breakpoint_axis_locator #(
    parameter int MAX_POINTS = bal_pkg::MAX_POINTS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  bal_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output bal_pkg::t_out_item        o_out_data,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [bal_pkg::CFG_W-1:0] i_cfg_data
);
    import bal_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);

    logic [CFG_W-1:0] r_points;
    logic             r_out_valid;
    t_out_item        r_out_data;

    logic             w_in_accept;
    logic             w_out_free;
    t_seq_stat        w_stat;
    t_out_item        w_result;
    logic             w_ram_we;
    logic [IW-1:0]    w_ram_waddr;
    logic [15:0]      w_ram_wdata;
    logic [IW-1:0]    w_ram_raddr;
    logic [15:0]      w_ram_rdata;

    // Request handshake
    assign o_in_stall  = w_stat.busy;
    assign w_in_accept = i_in_valid && !w_stat.busy;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_cfg_ready = 1'b1;

    // Point count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_points <= i_cfg_data;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_stat.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stat.done) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Axis storage
    bal_ram #(
        .WIDTH (16),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Search and fraction sequencer
    bal_seq #(
        .MAX_POINTS (MAX_POINTS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_in_accept),
        .i_item      (i_in_data),
        .i_points    (r_points),
        .i_out_free  (w_out_free),
        .o_stat      (w_stat),
        .o_result    (w_result),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    `BAL_ASSERT_NEXT(a_busy_after_accept, w_in_accept, o_in_stall, "sequencer idle after accept")
    `BAL_ASSERT_NEXT(a_valid_after_done, w_stat.done, o_out_valid, "result lost after done")

endmodule

// ===== dv/breakpoint_axis_locator_test.sv =====
// ----------------------------------------------------------------------------
// Breakpoint axis locator testbench
// Loads breakpoint axes, locates values on them and checks every result
// against an in-bench predictor, across several points_in_use settings and
// with random idling on both request and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module breakpoint_axis_locator_test;

    import bal_pkg::*;

    localparam int AXIS_DEPTH = MAX_POINTS_DEF;

    // DUT-facing signals, known from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [CFG_W-1:0]   i_cfg_data  = '0;

    // Predictor state: axis contents and points_in_use as the block holds them
    logic [15:0]        axis_model [AXIS_DEPTH];
    logic [CFG_W-1:0]   points_in_use_model = CFG_RESET;

    // Axis to be loaded by the next load_axis call
    logic [15:0]        axis_plan [AXIS_DEPTH];

    t_out_item          expected_results [$];
    int                 error_count = 0;
    int                 requests_sent = 0;
    bit                 sender_idle = 1'b0;
    bit                 sink_idle = 1'b0;
    int                 stall_left = 0;

    breakpoint_axis_locator #(
        .MAX_POINTS (MAX_POINTS_DEF)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Print one mismatch line and count it
    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Append one expected result behind those still pending
    function automatic void queue_expected(input t_out_item want);
        expected_results.insert(expected_results.size(), want);
    endfunction

    function automatic int gap_between(input int x, input int y);
        return (x > y) ? x - y : y - x;
    endfunction

    // Clamp the register to the range the search really uses
    function automatic int active_points();
        int n;
        n = points_in_use_model;
        if (n < 2) n = 2;
        if (n > AXIS_DEPTH) n = AXIS_DEPTH;
        return n;
    endfunction

    // Binary search, nearer-point pick and Q0.16 fraction of one locate
    function automatic t_out_item locate_expected(input logic [15:0] val);
        int        n, a, b, k;
        int        pk, pj, span, d1, d2, delta;
        t_out_item r;
        r = '0;
        n = active_points();
        a = 0;
        b = n;
        k = 0;
        while (a < b) begin
            k = a + ((b - a) >> 1);
            if (val == axis_model[k]) break;
            if (val > axis_model[k]) a = k + 1;
            else b = k;
        end
        pk = axis_model[k];
        if (k + 1 < n) begin
            pj   = axis_model[k + 1];
            span = gap_between(pk, pj);
            d1   = gap_between(pk, val);
            d2   = gap_between(pj, val);
            // A tie keeps k; a flat span always keeps k
            if (span != 0 && d1 > d2) begin
                r.nearest_index = 4'(k + 1);
                delta = d2;
            end else begin
                r.nearest_index = 4'(k);
                delta = d1;
            end
        end else begin
            // Final point: fraction over the span back to k-1
            pj    = axis_model[k - 1];
            span  = gap_between(pj, pk);
            delta = gap_between(pk, val);
            r.nearest_index = 4'(k);
        end
        if (span == 0) begin
            r.degenerate_span = 1'b1;
        end else if (delta >= span) begin
            r.span_fraction      = 16'hFFFF;
            r.fraction_saturated = 1'b1;
        end else begin
            r.span_fraction = 16'((longint'(delta) << 16) / longint'(span));
        end
        return r;
    endfunction

    // Send one request, hold it until accepted, then record its expected result
    task automatic send_request(input t_in_item req);
        int gap;
        if (sender_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (o_in_stall);
        if (req.opcode == OP_WRITE) begin
            axis_model[req.point_index] = req.sample_value;
            queue_expected('0);
        end else begin
            queue_expected(locate_expected(req.sample_value));
        end
        requests_sent++;
    endtask

    task automatic send_write(input int slot, input int val);
        t_in_item req;
        req.opcode       = OP_WRITE;
        req.point_index  = 4'(slot);
        req.sample_value = 16'(val);
        send_request(req);
    endtask

    task automatic send_locate(input int val);
        t_in_item req;
        req.opcode       = OP_LOCATE;
        req.point_index  = 4'($urandom_range(0, 15));
        req.sample_value = 16'(val);
        send_request(req);
    endtask

    task automatic load_axis();
        for (int i = 0; i < AXIS_DEPTH; i++) send_write(i, axis_plan[i]);
    endtask

    // Drop valid and hold off until every pending result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Write points_in_use while the block is idle
    task automatic write_points_in_use(input logic [CFG_W-1:0] val);
        drain_results();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        points_in_use_model = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void plan_even_axis();
        for (int i = 0; i < AXIS_DEPTH - 1; i++) axis_plan[i] = 16'(1000 + i * 4000);
        axis_plan[AXIS_DEPTH - 1] = 16'hFFFF;
    endfunction

    // Ascending axis: ends, exact hits, a tie and the last span
    task automatic test_load_and_locate();
        plan_even_axis();
        load_axis();
        send_locate(0);
        send_locate(1000);
        send_locate(3000);
        send_locate(3001);
        send_locate(33000);
        send_locate(59000);
        send_locate(61268);
        send_locate(65535);
    endtask

    // Flat spans inside and at the end of the axis, then an unsorted axis
    task automatic test_special_axes();
        send_write(7, 25000);
        send_locate(25000);
        send_locate(26000);
        send_write(15, 57000);
        send_locate(65535);
        send_write(2, 60000);
        send_locate(9000);
        send_locate(60000);
    endtask

    // Register extremes, including values that clamp to 2 and to the depth
    task automatic test_register_extremes();
        logic [CFG_W-1:0] settings [6];
        settings = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
        plan_even_axis();
        load_axis();
        foreach (settings[i]) begin
            write_points_in_use(settings[i]);
            send_locate(0);
            send_locate(65535);
            send_locate($urandom_range(0, 65535));
        end
    endtask

    // One phase: maybe a new setting, a fresh axis, then a burst of locates
    task automatic run_random_phase(input bit allow_idle);
        int kind, level, step_max, count, pick, j, val, off;
        if ($urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 3) == 0) write_points_in_use(5'($urandom_range(0, 31)));
            else write_points_in_use(5'($urandom_range(2, 16)));
        end
        sender_idle = allow_idle && ($urandom_range(0, 3) != 0);
        sink_idle   = allow_idle && ($urandom_range(0, 3) != 0);

        kind = $urandom_range(0, 7);
        if (kind == 0) begin
            // Noise axis: no order at all
            foreach (axis_plan[i]) axis_plan[i] = 16'($urandom_range(0, 65535));
        end else begin
            // Ascending axis; zero steps give flat spans, clipping flattens the top
            case ($urandom_range(0, 2))
                0: step_max = 4;
                1: step_max = 400;
                default: step_max = 4400;
            endcase
            level = $urandom_range(0, 20000);
            foreach (axis_plan[i]) begin
                axis_plan[i] = (level > 65535) ? 16'hFFFF : 16'(level);
                level += $urandom_range(0, step_max);
            end
        end
        load_axis();

        count = $urandom_range(20, 60);
        repeat (count) begin
            pick = $urandom_range(0, 9);
            j    = $urandom_range(0, active_points() - 1);
            if (pick == 0) begin
                send_write($urandom_range(0, 15), $urandom_range(0, 65535));
            end else if (pick <= 2) begin
                send_locate($urandom_range(0, 65535));
            end else if (pick <= 4) begin
                send_locate(axis_model[j]);
            end else begin
                off = (pick == 9) ? 4000 : 40;
                val = int'(axis_model[j]) + $urandom_range(0, 2 * off) - off;
                if (val < 0) val = 0;
                if (val > 65535) val = 65535;
                send_locate(val);
            end
        end
    endtask

    task automatic test_random_traffic();
        while (requests_sent < 1500) run_random_phase(1'b1);
    endtask

    // Back-to-back requests with the result side never stalled
    task automatic test_steady_stream();
        while (requests_sent < 1650) run_random_phase(1'b0);
    endtask

    // Random result stall bursts while sink idling is enabled
    always @(negedge i_clk) begin
        if (!sink_idle) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Compare each accepted result with the oldest pending one
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                flag_error($sformatf("result with no request pending: %h", o_out_data));
            end else begin
                want = expected_results.pop_front();
                if (o_out_data.nearest_index !== want.nearest_index)
                    flag_error($sformatf("nearest_index got %0d want %0d",
                        o_out_data.nearest_index, want.nearest_index));
                if (o_out_data.span_fraction !== want.span_fraction)
                    flag_error($sformatf("span_fraction got %h want %h",
                        o_out_data.span_fraction, want.span_fraction));
                if (o_out_data.fraction_saturated !== want.fraction_saturated)
                    flag_error($sformatf("fraction_saturated got %b want %b",
                        o_out_data.fraction_saturated, want.fraction_saturated));
                if (o_out_data.degenerate_span !== want.degenerate_span)
                    flag_error($sformatf("degenerate_span got %b want %b",
                        o_out_data.degenerate_span, want.degenerate_span));
            end
        end
    end

    // Run limit, well above the slowest correct run
    initial begin
        #2000000;
        $display("breakpoint_axis_locator_test: done, errors");
        $finish;
    end

    initial begin
        foreach (axis_model[i]) axis_model[i] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_load_and_locate();
        test_special_axes();
        test_register_extremes();
        test_random_traffic();
        test_steady_stream();

        drain_results();
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("breakpoint_axis_locator_test: done, clean");
        end else begin
            $display("breakpoint_axis_locator_test: done, errors");
        end
        $finish;
    end

endmodule
